### rtl/core/frc_pkg.sv
package frc_pkg;

  localparam logic [7:0]  SyncFirst   = 8'hEF;
  localparam logic [7:0]  SyncSecond  = 8'h01;
  localparam logic [15:0] AddrBytes   = 16'd4;
  localparam logic [15:0] MinLength   = 16'd3;
  localparam logic [15:0] DataIndex   = 16'd2;
  localparam logic [15:0] SumBytes    = 16'd2;

  localparam logic [7:0]  ResetIdent  = 8'd7;
  localparam logic [15:0] ResetMaxLen = 16'd91;

  localparam int unsigned AddrWidth   = 3;

  typedef enum logic {
    REG_REPLY_IDENT = 1'b0,
    REG_MAX_LENGTH  = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    PH_HUNT0   = 4'd0,
    PH_HUNT1   = 4'd1,
    PH_ADDR    = 4'd2,
    PH_IDENT   = 4'd3,
    PH_LENHI   = 4'd4,
    PH_LENLO   = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_SUMHI   = 4'd7,
    PH_SUMLO   = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_CONFIRM   = 3'd1,
    STATUS_SUM_BAD   = 3'd2,
    STATUS_IDENT_BAD = 3'd3,
    STATUS_LEN_BAD   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0]  reply_ident;
    logic [15:0] max_length;
  } cfg_t;

endpackage

### rtl/core/frc_if.sv
interface frc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       restart;

  modport source (output valid, output rx_byte, output restart, input ready);
  modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

interface frc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  frame_status;
  logic [7:0]  confirm_code;
  logic [7:0]  data_byte;
  logic [15:0] frame_length;

  modport source (output valid, output frame_status, output confirm_code,
                  output data_byte, output frame_length, input ready);
  modport sink   (input valid, input frame_status, input confirm_code,
                  input data_byte, input frame_length, output ready);
endinterface

### rtl/core/frc_cfg_regs.sv
module frc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [frc_pkg::AddrWidth-1:0]       paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output frc_pkg::cfg_t                       cfg_o
);

  frc_pkg::cfg_t      cfg_q, cfg_d;
  frc_pkg::reg_idx_e  reg_idx;
  logic               wr_en;

  assign reg_idx = frc_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        frc_pkg::REG_REPLY_IDENT: cfg_d.reply_ident = pwdata[7:0];
        frc_pkg::REG_MAX_LENGTH:  cfg_d.max_length  = pwdata[15:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      frc_pkg::REG_REPLY_IDENT: prdata = {24'b0, cfg_q.reply_ident};
      frc_pkg::REG_MAX_LENGTH:  prdata = {16'b0, cfg_q.max_length};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reply_ident <= frc_pkg::ResetIdent;
      cfg_q.max_length  <= frc_pkg::ResetMaxLen;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/frc_parser.sv
module frc_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  frc_pkg::cfg_t cfg_i,
  frc_in_if.sink        rx_i,
  frc_out_if.source     res_o
);

  frc_pkg::phase_e  phase_q, phase_d, cur_phase;
  logic [15:0]      count_q, count_d, cur_count, count_inc;
  logic [15:0]      len_q, len_d, cur_len, len_full;
  logic [15:0]      sum_q, sum_d, cur_sum, sum_add;
  logic [7:0]       conf_q, conf_d, cur_conf;
  logic [7:0]       data_q, data_d, cur_data;
  logic [7:0]       sumhi_q, sumhi_d, cur_sumhi;
  logic [7:0]       b;
  logic             accept, len_bad, ident_bad, sum_good;

  logic             emit;
  frc_pkg::status_e st;
  logic [7:0]       r_conf, r_data;
  logic [15:0]      r_len;

  logic             out_valid_q, out_valid_d;
  frc_pkg::status_e out_status_q;
  logic [7:0]       out_conf_q, out_data_q;
  logic [15:0]      out_len_q;

  assign b         = rx_i.rx_byte;
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept    = rx_i.valid && rx_i.ready;

  // restart drops the partial frame before the byte is examined
  assign cur_phase = rx_i.restart ? frc_pkg::PH_HUNT0 : phase_q;
  assign cur_count = rx_i.restart ? '0 : count_q;
  assign cur_len   = rx_i.restart ? '0 : len_q;
  assign cur_sum   = rx_i.restart ? '0 : sum_q;
  assign cur_conf  = rx_i.restart ? '0 : conf_q;
  assign cur_data  = rx_i.restart ? '0 : data_q;
  assign cur_sumhi = rx_i.restart ? '0 : sumhi_q;

  assign count_inc = cur_count + 16'd1;
  assign sum_add   = cur_sum + {8'b0, b};
  assign len_full  = {cur_len[15:8], b};
  assign len_bad   = (len_full < frc_pkg::MinLength) || (len_full > cfg_i.max_length);
  assign ident_bad = b != cfg_i.reply_ident;
  assign sum_good  = (cur_sumhi == cur_sum[15:8]) && (b == cur_sum[7:0]);

  always_comb begin
    case (cur_phase)
      frc_pkg::PH_HUNT0: phase_d = (b == frc_pkg::SyncFirst) ? frc_pkg::PH_HUNT1
                                                            : frc_pkg::PH_HUNT0;
      frc_pkg::PH_HUNT1: begin
        if (b == frc_pkg::SyncSecond) begin
          phase_d = frc_pkg::PH_ADDR;
        end else if (b != frc_pkg::SyncFirst) begin
          phase_d = frc_pkg::PH_HUNT0;
        end else begin
          phase_d = frc_pkg::PH_HUNT1;
        end
      end
      frc_pkg::PH_ADDR:    phase_d = (count_inc >= frc_pkg::AddrBytes) ? frc_pkg::PH_IDENT
                                                                      : frc_pkg::PH_ADDR;
      frc_pkg::PH_IDENT:   phase_d = ident_bad ? frc_pkg::PH_HUNT0 : frc_pkg::PH_LENHI;
      frc_pkg::PH_LENHI:   phase_d = frc_pkg::PH_LENLO;
      frc_pkg::PH_LENLO:   phase_d = len_bad ? frc_pkg::PH_HUNT0 : frc_pkg::PH_PAYLOAD;
      frc_pkg::PH_PAYLOAD: phase_d = (count_inc >= cur_len - frc_pkg::SumBytes)
                                     ? frc_pkg::PH_SUMHI : frc_pkg::PH_PAYLOAD;
      frc_pkg::PH_SUMHI:   phase_d = frc_pkg::PH_SUMLO;
      frc_pkg::PH_SUMLO:   phase_d = frc_pkg::PH_HUNT0;
      default:             phase_d = frc_pkg::PH_HUNT0;
    endcase
  end

  always_comb begin
    logic clear;
    clear   = 1'b0;
    count_d = cur_count;
    len_d   = cur_len;
    sum_d   = cur_sum;
    conf_d  = cur_conf;
    data_d  = cur_data;
    sumhi_d = cur_sumhi;
    emit    = 1'b0;
    st      = frc_pkg::STATUS_OK;
    r_conf  = '0;
    r_data  = '0;
    r_len   = '0;
    case (cur_phase)
      frc_pkg::PH_HUNT0: ;
      frc_pkg::PH_HUNT1: begin
        if (b == frc_pkg::SyncSecond) count_d = '0;
      end
      frc_pkg::PH_ADDR: count_d = count_inc;
      frc_pkg::PH_IDENT: begin
        if (ident_bad) begin
          emit  = 1'b1;
          st    = frc_pkg::STATUS_IDENT_BAD;
          clear = 1'b1;
        end else begin
          sum_d = {8'b0, b};
        end
      end
      frc_pkg::PH_LENHI: begin
        len_d = {b, 8'h00};
        sum_d = sum_add;
      end
      frc_pkg::PH_LENLO: begin
        len_d = len_full;
        sum_d = sum_add;
        if (len_bad) begin
          emit  = 1'b1;
          st    = frc_pkg::STATUS_LEN_BAD;
          r_len = len_full;
          clear = 1'b1;
        end else begin
          count_d = '0;
        end
      end
      frc_pkg::PH_PAYLOAD: begin
        if (cur_count == '0) conf_d = b;
        if (cur_count == frc_pkg::DataIndex) data_d = b;
        sum_d   = sum_add;
        count_d = count_inc;
      end
      frc_pkg::PH_SUMHI: begin
        if (cur_count == frc_pkg::DataIndex) data_d = b;
        sumhi_d = b;
        count_d = count_inc;
      end
      frc_pkg::PH_SUMLO: begin
        emit   = 1'b1;
        st     = !sum_good ? frc_pkg::STATUS_SUM_BAD
               : (cur_conf != '0) ? frc_pkg::STATUS_CONFIRM : frc_pkg::STATUS_OK;
        r_conf = cur_conf;
        r_data = (cur_len > frc_pkg::MinLength) ? cur_data : '0;
        r_len  = cur_len;
        clear  = 1'b1;
      end
      default: clear = 1'b1;
    endcase
    if (clear) begin
      count_d = '0;
      len_d   = '0;
      sum_d   = '0;
      conf_d  = '0;
      data_d  = '0;
      sumhi_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= frc_pkg::PH_HUNT0;
      count_q     <= '0;
      len_q       <= '0;
      sum_q       <= '0;
      conf_q      <= '0;
      data_q      <= '0;
      sumhi_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q <= phase_d;
        count_q <= count_d;
        len_q   <= len_d;
        sum_q   <= sum_d;
        conf_q  <= conf_d;
        data_q  <= data_d;
        sumhi_q <= sumhi_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_status_q <= st;
      out_conf_q   <= r_conf;
      out_data_q   <= r_data;
      out_len_q    <= r_len;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.frame_status = out_status_q;
  assign res_o.confirm_code = out_conf_q;
  assign res_o.data_byte    = out_data_q;
  assign res_o.frame_length = out_len_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> out_valid_q)
    else $error("input stalled with empty result register");

  a_confirm_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == frc_pkg::STATUS_CONFIRM) |-> out_conf_q != '0)
    else $error("confirm status with zero confirm code");

  a_data_needs_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q != '0) |-> out_len_q > frc_pkg::MinLength)
    else $error("data byte reported for short frame");

  a_hunt_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && emit |=> phase_q == frc_pkg::PH_HUNT0)
    else $error("frame state not cleared after result");

endmodule

### rtl/core/fingerprint_reply_frame_checker_unit.sv
// Channel   Dir  Handshake      Payload
// byte_in   in   valid/ready    rx_byte[7:0], restart
// result    out  valid/ready    frame_status[2:0], confirm_code[7:0],
//                               data_byte[7:0], frame_length[15:0]
// apb       in   psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0], pready
//
// One byte per cycle unless a full result register stalls byte_in; a frame result is
// registered as its last byte is accepted. Frame state updates on each accepted byte.
// Reset clears the frame state and the result valid, and loads the register defaults.
// byte_in is taken whenever the result register is empty or is being drained.
module fingerprint_reply_frame_checker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  frc_in_if.sink                        byte_in_i,
  frc_out_if.source                     result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  frc_pkg::cfg_t cfg;

  frc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  frc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .rx_i   (byte_in_i),
    .res_o  (result_o)
  );

endmodule

### bench/fingerprint_reply_frame_checker_unit_test.sv
import frc_pkg::*;

typedef struct packed {
  status_e     status;
  logic [7:0]  confirm;
  logic [7:0]  data;
  logic [15:0] length;
} frame_report_t;

class reply_frame_tracker;
  logic [7:0]    reply_ident;
  logic [15:0]   max_length;
  phase_e        phase;
  logic [15:0]   count;
  logic [15:0]   length;
  logic [15:0]   sum;
  logic [7:0]    confirm;
  logic [7:0]    data;
  logic [7:0]    sum_high;
  frame_report_t expected_reports[$];
  int            mismatches;
  int            status_seen[5];

  function new();
    reply_ident = ResetIdent;
    max_length  = ResetMaxLen;
    mismatches  = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    clear();
  endfunction

  function void clear();
    phase    = PH_HUNT0;
    count    = '0;
    length   = '0;
    sum      = '0;
    confirm  = '0;
    data     = '0;
    sum_high = '0;
  endfunction

  function void post(status_e st, logic [7:0] c, logic [7:0] d, logic [15:0] len);
    frame_report_t r;
    r.status  = st;
    r.confirm = c;
    r.data    = d;
    r.length  = len;
    expected_reports.push_back(r);
    clear();
  endfunction

  function void take_byte(logic [7:0] b, logic restart);
    logic    good;
    status_e st;
    if (restart) clear();
    case (phase)
      PH_HUNT0: begin
        if (b == SyncFirst) phase = PH_HUNT1;
      end
      PH_HUNT1: begin
        if (b == SyncSecond) begin
          phase = PH_ADDR;
          count = '0;
        end else if (b != SyncFirst) begin
          phase = PH_HUNT0;
        end
      end
      PH_ADDR: begin
        count = count + 16'd1;
        if (count >= AddrBytes) phase = PH_IDENT;
      end
      PH_IDENT: begin
        if (b != reply_ident) begin
          post(STATUS_IDENT_BAD, 8'h00, 8'h00, 16'h0000);
        end else begin
          sum   = {8'h00, b};
          phase = PH_LENHI;
        end
      end
      PH_LENHI: begin
        length = {b, 8'h00};
        sum    = sum + {8'h00, b};
        phase  = PH_LENLO;
      end
      PH_LENLO: begin
        length[7:0] = b;
        sum         = sum + {8'h00, b};
        if (length < MinLength || length > max_length) begin
          post(STATUS_LEN_BAD, 8'h00, 8'h00, length);
        end else begin
          count = '0;
          phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (count == 16'd0) confirm = b;
        if (count == DataIndex) data = b;
        sum   = sum + {8'h00, b};
        count = count + 16'd1;
        if (count >= length - SumBytes) phase = PH_SUMHI;
      end
      PH_SUMHI: begin
        if (count == DataIndex) data = b;
        sum_high = b;
        count    = count + 16'd1;
        phase    = PH_SUMLO;
      end
      PH_SUMLO: begin
        good = (sum_high == sum[15:8]) && (b == sum[7:0]);
        st   = !good ? STATUS_SUM_BAD : (confirm != 8'h00 ? STATUS_CONFIRM : STATUS_OK);
        post(st, confirm, (length > MinLength) ? data : 8'h00, length);
      end
      default: clear();
    endcase
  endfunction

  task report_mismatch(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  task check_report(logic [2:0] st, logic [7:0] c, logic [7:0] d, logic [15:0] len);
    frame_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("unexpected report status %0d length %0d", st, len));
      return;
    end
    want = expected_reports.pop_front();
    if (st <= STATUS_LEN_BAD) status_seen[st]++;
    if (st !== want.status)
      report_mismatch($sformatf("frame_status %0d, want %0d", st, want.status));
    if (c !== want.confirm)
      report_mismatch($sformatf("confirm_code %0h, want %0h", c, want.confirm));
    if (d !== want.data)
      report_mismatch($sformatf("data_byte %0h, want %0h", d, want.data));
    if (len !== want.length)
      report_mismatch($sformatf("frame_length %0d, want %0d", len, want.length));
  endtask
endclass

module fingerprint_reply_frame_checker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_IDENT,
    FR_BAD_LEN,
    FR_CUT,
    FR_NOISE
  } frame_kind_e;

  localparam int CycleLimit   = 500000;
  localparam int SettleCycles = 8;
  localparam int ByteTarget   = 1700;
  localparam int Phases       = 6;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  frc_in_if  byte_if ();
  frc_out_if res_if ();

  reply_frame_tracker tracker = new();
  int n_taken     = 0;
  int n_reports   = 0;
  int cycle_count = 0;
  bit calm        = 1'b0;

  fingerprint_reply_frame_checker_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_in_i(byte_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL fingerprint_reply_frame_checker_unit");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (res_if.valid && res_if.ready) begin
        tracker.check_report(res_if.frame_status, res_if.confirm_code, res_if.data_byte,
                             res_if.frame_length);
        n_reports++;
      end
      if (byte_if.valid && byte_if.ready) begin
        tracker.take_byte(byte_if.rx_byte, byte_if.restart);
        n_taken++;
      end
    end
  end

  initial begin
    int stall;
    int seen;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      seen = n_reports;
      @(negedge clk_i);
      while (n_reports == seen) @(negedge clk_i);
    end
  end

  task automatic send_byte(logic [7:0] b, logic rs);
    int gap;
    int seen;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_if.valid   <= 1'b1;
    byte_if.rx_byte <= b;
    byte_if.restart <= rs;
    seen = n_taken;
    @(negedge clk_i);
    while (n_taken == seen) @(negedge clk_i);
  endtask

  task automatic send_frame(frame_kind_e kind, logic [15:0] len, logic [7:0] conf,
                            int lead_sync, logic rs_first);
    logic [7:0]  q[$];
    logic [15:0] sum;
    logic [7:0]  id;
    logic [7:0]  b;
    logic [7:0]  mask;
    int          pay_n;
    int          keep;
    repeat (lead_sync) q.push_back(SyncFirst);
    q.push_back(SyncFirst);
    q.push_back(SyncSecond);
    repeat (AddrBytes) q.push_back(8'($urandom_range(0, 255)));
    id = tracker.reply_ident;
    if (kind == FR_BAD_IDENT) id = id ^ 8'($urandom_range(1, 255));
    q.push_back(id);
    if (kind != FR_BAD_IDENT) begin
      q.push_back(len[15:8]);
      q.push_back(len[7:0]);
      sum = {8'h00, id} + {8'h00, len[15:8]} + {8'h00, len[7:0]};
      if (kind != FR_BAD_LEN) begin
        pay_n = (kind == FR_CUT && len > 16'd10) ? 8 : int'(len) - 2;
        for (int i = 0; i < pay_n; i++) begin
          b = (i == 0) ? conf : 8'($urandom_range(0, 255));
          q.push_back(b);
          sum = sum + {8'h00, b};
        end
        if (kind == FR_BAD_SUM) begin
          mask = 8'($urandom_range(1, 255));
          sum  = sum ^ ($urandom_range(0, 1) ? {mask, 8'h00} : {8'h00, mask});
        end
        q.push_back(sum[15:8]);
        q.push_back(sum[7:0]);
      end
    end
    keep = (kind == FR_CUT) ? $urandom_range(1, q.size() - 1) : q.size();
    for (int i = 0; i < keep; i++) send_byte(q[i], (i == 0) ? rs_first : 1'b0);
  endtask

  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_REPLY_IDENT: tracker.reply_ident = value[7:0];
      REG_MAX_LENGTH:  tracker.max_length  = value[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] good_length();
    int top;
    top = (tracker.max_length > 16'd24) ? 24 : int'(tracker.max_length);
    if ($urandom_range(0, 39) == 0)
      top = (tracker.max_length > 16'd300) ? 300 : int'(tracker.max_length);
    if ($urandom_range(0, 29) == 0 && tracker.max_length <= 16'd300)
      return tracker.max_length;
    return 16'($urandom_range(int'(MinLength), top));
  endfunction

  function automatic logic [15:0] bad_length();
    if (tracker.max_length == 16'hFFFF || $urandom_range(0, 1) == 0)
      return 16'($urandom_range(0, int'(MinLength) - 1));
    return 16'($urandom_range(int'(tracker.max_length) + 1, 65535));
  endfunction

  initial begin
    frame_kind_e kind;
    int          pick;
    int          lead;
    int          budget;
    logic        rs_next;
    logic [7:0]  conf;

    rst_ni          = 1'b0;
    byte_if.valid   = 1'b0;
    byte_if.rx_byte = 8'h00;
    byte_if.restart = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_frame(FR_GOOD, 16'd3, 8'h00, 0, 1'b0);
    send_frame(FR_GOOD, 16'd4, 8'hFF, 0, 1'b0);
    send_frame(FR_BAD_IDENT, 16'd3, 8'h00, 0, 1'b0);
    send_frame(FR_BAD_LEN, 16'd0, 8'h00, 0, 1'b0);
    send_frame(FR_BAD_LEN, tracker.max_length + 16'd1, 8'h00, 0, 1'b0);
    send_frame(FR_BAD_SUM, 16'd5, 8'h80, 0, 1'b0);
    send_frame(FR_GOOD, 16'd6, 8'h00, 2, 1'b0);
    send_frame(FR_CUT, 16'd8, 8'h01, 0, 1'b0);
    send_frame(FR_GOOD, 16'd4, 8'h00, 0, 1'b1);

    rs_next = 1'b0;
    for (int p = 0; p < Phases; p++) begin
      if (p > 0) begin
        wait_drained();
        case (p)
          1: begin
            apb_write(REG_REPLY_IDENT, 32'd0);
            apb_write(REG_MAX_LENGTH, 32'(MinLength));
          end
          2: begin
            apb_write(REG_REPLY_IDENT, 32'd255);
            apb_write(REG_MAX_LENGTH, 32'd65535);
          end
          3: begin
            apb_write(REG_REPLY_IDENT, $urandom_range(0, 255));
            apb_write(REG_MAX_LENGTH, $urandom_range(3, 120));
          end
          4: begin
            apb_write(REG_REPLY_IDENT, $urandom_range(0, 255));
            apb_write(REG_MAX_LENGTH, 32'd4);
          end
          default: begin
            apb_write(REG_REPLY_IDENT, 32'(ResetIdent));
            apb_write(REG_MAX_LENGTH, 32'(ResetMaxLen));
          end
        endcase
      end
      budget = n_taken + ByteTarget / Phases;
      while (n_taken < budget) begin
        if ($urandom_range(0, 7) == 0) calm = !calm;
        pick = $urandom_range(0, 99);
        if (pick < 55) kind = FR_GOOD;
        else if (pick < 67) kind = FR_BAD_SUM;
        else if (pick < 76) kind = FR_BAD_IDENT;
        else if (pick < 85) kind = FR_BAD_LEN;
        else if (pick < 93) kind = FR_CUT;
        else kind = FR_NOISE;
        conf = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        lead = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        case (kind)
          FR_NOISE: begin
            repeat ($urandom_range(1, 6))
              send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
          end
          FR_BAD_LEN: send_frame(kind, bad_length(), conf, lead, rs_next);
          FR_CUT: begin
            send_frame(kind, 16'($urandom_range(int'(MinLength), int'(tracker.max_length))),
                       conf, lead, rs_next);
          end
          default: send_frame(kind, good_length(), conf, lead, rs_next);
        endcase
        rs_next = (kind == FR_CUT) || ($urandom_range(0, 4) == 0);
      end
    end

    wait_drained();
    $display("run covered %0d bytes and %0d frame reports over %0d register settings",
             n_taken, n_reports, Phases);
    $display("reports seen: ok %0d, confirm %0d, checksum %0d, ident %0d, length %0d",
             tracker.status_seen[STATUS_OK], tracker.status_seen[STATUS_CONFIRM],
             tracker.status_seen[STATUS_SUM_BAD], tracker.status_seen[STATUS_IDENT_BAD],
             tracker.status_seen[STATUS_LEN_BAD]);
    if (tracker.mismatches == 0) begin
      $display("PASS fingerprint_reply_frame_checker_unit");
    end else begin
      $display("FAIL fingerprint_reply_frame_checker_unit");
    end
    $finish;
  end

endmodule
